// ===== src/ent_pkg.sv =====
// Shared constants and types for the excitable network tick block.
package ent_pkg;

    localparam int NODE_COUNT = 256;
    localparam int TIMER_BITS = 4;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int CNT_BITS   = $clog2(NODE_COUNT + 1);
    localparam int LINK_BITS  = $clog2(NODE_COUNT * NODE_COUNT + 1);
    localparam int IN_BITS    = CNT_BITS + 5;

    localparam int PROBE_MAX = 4095;
    localparam int PROBE_MIN = -4096;

    // command codes
    localparam logic [1:0] CMD_EDGE  = 2'd0;
    localparam logic [1:0] CMD_FORCE = 2'd1;
    localparam logic [1:0] CMD_STIM  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_EXC_COUNT = 3'd0;
    localparam logic [2:0] REG_EXC_TIME  = 3'd1;
    localparam logic [2:0] REG_INH_TIME  = 3'd2;
    localparam logic [2:0] REG_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_WEIGHT    = 3'd4;
    localparam logic [2:0] REG_PROBE     = 3'd5;

    typedef struct packed {
        logic                  adj;
        logic [TIMER_BITS-1:0] tmr;
    } t_link;

    typedef t_link [NODE_COUNT-1:0] t_row;

endpackage

// ===== src/ent_if.sv =====
// Channel interfaces: command in, result out, configuration write.
interface ent_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] src_node;
    logic [7:0] dst_node;
    logic       edge_value;
    modport source (output valid, cmd, src_node, dst_node, edge_value, input ready);
    modport sink (input valid, cmd, src_node, dst_node, edge_value, output ready);
endinterface

interface ent_res_if;
    logic               valid;
    logic               ready;
    logic [16:0]        active_exc_links;
    logic [16:0]        active_inh_links;
    logic [8:0]         active_exc_nodes;
    logic [8:0]         active_inh_nodes;
    logic signed [12:0] probe_input;
    modport source (output valid, active_exc_links, active_inh_links, active_exc_nodes,
                    active_inh_nodes, probe_input, input ready);
    modport sink (input valid, active_exc_links, active_inh_links, active_exc_nodes,
                  active_inh_nodes, probe_input, output ready);
endinterface

interface ent_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/excitable_network_tick.sv =====
// Directed threshold-neuron network. Adjacency bits and link timers live in one RAM, one
// row per source node. Edge writes read the row, modify it and write it back; force and
// stimulus commands only set a bit in a register. A tick first reads each RAM row to update
// timers and accumulate per-destination link counts, then evaluates each node for firing
// and totals. A finished tick waits in its last state while the previous summary still
// sits unread in the output register, and no command is taken meanwhile. After reset the
// RAM is cleared one row per cycle, and no command is taken until it is done.
module excitable_network_tick (
    input  logic i_clk,
    input  logic i_rst_n,
    ent_cmd_if.sink   i_cmd,
    ent_res_if.source o_res,
    ent_cfg_if.sink   i_cfg
);
    import ent_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EDGE  = 3'd2;
    localparam logic [2:0] S_ROW   = 3'd3;
    localparam logic [2:0] S_NODE  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]           r_state;
    logic [NODE_BITS:0]   r_cnt;

    logic [8:0]           r_exc_count;
    logic [3:0]           r_exc_time;
    logic [3:0]           r_inh_time;
    logic signed [12:0]   r_thr;
    logic [3:0]           r_weight;
    logic [7:0]           r_probe;

    logic [NODE_COUNT-1:0] r_node_act;
    logic [NODE_COUNT-1:0] r_stim;
    logic [CNT_BITS-1:0]   r_exc_in [NODE_COUNT];
    logic [CNT_BITS-1:0]   r_inh_in [NODE_COUNT];

    logic [NODE_BITS-1:0] r_edge_row;
    logic [NODE_BITS-1:0] r_edge_dst;
    logic                 r_edge_val;

    logic                 r_rd_vld;
    logic [NODE_BITS-1:0] r_rd_row;
    logic                 r_rd_act;
    logic                 r_rd_exc;
    logic [3:0]           r_rd_lim;

    logic [LINK_BITS-1:0] r_lnk_exc;
    logic [LINK_BITS-1:0] r_lnk_inh;
    logic [CNT_BITS-1:0]  r_nd_exc;
    logic [CNT_BITS-1:0]  r_nd_inh;
    logic signed [12:0]   r_probe_val;

    logic                 r_out_vld;
    logic [16:0]          r_out_lexc;
    logic [16:0]          r_out_linh;
    logic [8:0]           r_out_nexc;
    logic [8:0]           r_out_ninh;
    logic signed [12:0]   r_out_probe;

    logic                 ram_we;
    logic [NODE_BITS-1:0] ram_waddr;
    t_row                 ram_wdata;
    logic [NODE_BITS-1:0] ram_raddr;
    t_row                 ram_rdata;

    logic                 cmd_xfer;
    logic                 src_ok;
    logic                 dst_ok;
    logic                 issue;
    t_row                 upd_row;
    t_row                 edge_row;
    logic [NODE_COUNT-1:0] lane_on;

    logic [NODE_BITS-1:0]      node_idx;
    logic [CNT_BITS+3:0]       inh_prod;
    logic signed [IN_BITS-1:0] node_in;
    logic                      fire;
    logic                      node_exc;
    logic signed [12:0]        in_sat;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;
    assign src_ok      = 32'(i_cmd.src_node) < NODE_COUNT;
    assign dst_ok      = 32'(i_cmd.dst_node) < NODE_COUNT;
    assign issue       = (r_state == S_ROW) && (32'(r_cnt) < NODE_COUNT);

    assign o_res.valid            = r_out_vld;
    assign o_res.active_exc_links = r_out_lexc;
    assign o_res.active_inh_links = r_out_linh;
    assign o_res.active_exc_nodes = r_out_nexc;
    assign o_res.active_inh_nodes = r_out_ninh;
    assign o_res.probe_input      = r_out_probe;

    // per-lane timer update of the returned row
    always_comb begin
        for (int d = 0; d < NODE_COUNT; d++) begin
            upd_row[d].adj = ram_rdata[d].adj;
            if (!ram_rdata[d].adj) begin
                upd_row[d].tmr = '0;
            end else if (ram_rdata[d].tmr == '0) begin
                upd_row[d].tmr = TIMER_BITS'(r_rd_act);
            end else if (32'(ram_rdata[d].tmr) < 32'(r_rd_lim)) begin
                upd_row[d].tmr = TIMER_BITS'(ram_rdata[d].tmr + 1'b1);
            end else begin
                upd_row[d].tmr = '0;
            end
            lane_on[d] = (upd_row[d].tmr != '0);
        end
    end

    always_comb begin
        edge_row                 = ram_rdata;
        edge_row[r_edge_dst].adj = r_edge_val;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rd_row;
        ram_wdata = upd_row;
        ram_raddr = r_cnt[NODE_BITS-1:0];
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[NODE_BITS-1:0];
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_raddr = NODE_BITS'(i_cmd.src_node);
            end
            S_EDGE: begin
                ram_we    = 1'b1;
                ram_waddr = r_edge_row;
                ram_wdata = edge_row;
            end
            S_ROW: begin
                ram_we = r_rd_vld;
            end
            S_NODE, S_DONE: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // node evaluation, node d sits at tap 0 of the rotating arrays
    always_comb begin
        node_idx = r_cnt[NODE_BITS-1:0];
        inh_prod = (CNT_BITS+4)'(r_weight * r_inh_in[0]);
        node_in  = $signed(IN_BITS'(r_exc_in[0])) - $signed(IN_BITS'(inh_prod));
        fire     = (int'(node_in) >= int'(r_thr)) || r_stim[0];
        node_exc = int'(node_idx) < int'(r_exc_count);
        if (int'(node_in) > PROBE_MAX) begin
            in_sat = 13'(PROBE_MAX);
        end else if (int'(node_in) < PROBE_MIN) begin
            in_sat = 13'(PROBE_MIN);
        end else begin
            in_sat = 13'(node_in);
        end
    end

    ent_ram #(.WIDTH($bits(t_row)), .DEPTH(NODE_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_exc_count <= 9'd205;
            r_exc_time  <= 4'd5;
            r_inh_time  <= 4'd7;
            r_thr       <= 13'sd4;
            r_weight    <= 4'd4;
            r_probe     <= 8'd0;
            r_node_act  <= '0;
            r_stim      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            for (int d = 0; d < NODE_COUNT; d++) begin
                r_exc_in[d] <= '0;
                r_inh_in[d] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_EXC_COUNT: r_exc_count <= i_cfg.data[8:0];
                    REG_EXC_TIME:  r_exc_time  <= i_cfg.data[3:0];
                    REG_INH_TIME:  r_inh_time  <= i_cfg.data[3:0];
                    REG_THRESHOLD: r_thr       <= $signed(i_cfg.data);
                    REG_WEIGHT:    r_weight    <= i_cfg.data[3:0];
                    REG_PROBE:     r_probe     <= i_cfg.data[7:0];
                    default: ;
                endcase
            end

            if (r_state == S_DONE && (!r_out_vld || o_res.ready)) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_res.ready) begin
                r_out_vld <= 1'b0;
            end

            r_rd_vld <= issue;

            unique case (r_state)
                S_CLEAR: begin
                    if (32'(r_cnt) == NODE_COUNT - 1) begin
                        r_state <= S_IDLE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (cmd_xfer) begin
                        unique case (i_cmd.cmd)
                            CMD_EDGE: begin
                                if (src_ok && dst_ok) begin
                                    r_state    <= S_EDGE;
                                    r_edge_row <= NODE_BITS'(i_cmd.src_node);
                                    r_edge_dst <= NODE_BITS'(i_cmd.dst_node);
                                    r_edge_val <= i_cmd.edge_value;
                                end
                            end
                            CMD_FORCE: begin
                                if (src_ok) begin
                                    r_node_act[NODE_BITS'(i_cmd.src_node)] <= 1'b1;
                                end
                            end
                            CMD_STIM: begin
                                if (src_ok) begin
                                    r_stim[NODE_BITS'(i_cmd.src_node)] <= 1'b1;
                                end
                            end
                            CMD_TICK: begin
                                r_state     <= S_ROW;
                                r_cnt       <= '0;
                                r_lnk_exc   <= '0;
                                r_lnk_inh   <= '0;
                                r_nd_exc    <= '0;
                                r_nd_inh    <= '0;
                                r_probe_val <= '0;
                                for (int d = 0; d < NODE_COUNT; d++) begin
                                    r_exc_in[d] <= '0;
                                    r_inh_in[d] <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_EDGE: begin
                    r_state <= S_IDLE;
                end
                S_ROW: begin
                    if (issue) begin
                        r_cnt      <= r_cnt + 1'b1;
                        r_rd_row   <= r_cnt[NODE_BITS-1:0];
                        r_rd_act   <= r_node_act[0];
                        r_rd_exc   <= int'(r_cnt) < int'(r_exc_count);
                        r_rd_lim   <= (int'(r_cnt) < int'(r_exc_count)) ? r_exc_time
                                                                         : r_inh_time;
                        r_node_act <= {r_node_act[0], r_node_act[NODE_COUNT-1:1]};
                    end else if (!r_rd_vld) begin
                        r_state <= S_NODE;
                        r_cnt   <= '0;
                    end
                    if (r_rd_vld) begin
                        for (int d = 0; d < NODE_COUNT; d++) begin
                            if (lane_on[d] && r_rd_exc) begin
                                r_exc_in[d] <= r_exc_in[d] + 1'b1;
                            end
                            if (lane_on[d] && !r_rd_exc) begin
                                r_inh_in[d] <= r_inh_in[d] + 1'b1;
                            end
                        end
                    end
                end
                S_NODE: begin
                    for (int d = 0; d < NODE_COUNT - 1; d++) begin
                        r_exc_in[d] <= r_exc_in[d+1];
                        r_inh_in[d] <= r_inh_in[d+1];
                    end
                    r_exc_in[NODE_COUNT-1] <= '0;
                    r_inh_in[NODE_COUNT-1] <= '0;
                    r_node_act <= {fire, r_node_act[NODE_COUNT-1:1]};
                    r_stim     <= {1'b0, r_stim[NODE_COUNT-1:1]};
                    r_lnk_exc  <= r_lnk_exc + LINK_BITS'(r_exc_in[0]);
                    r_lnk_inh  <= r_lnk_inh + LINK_BITS'(r_inh_in[0]);
                    if (fire && node_exc) begin
                        r_nd_exc <= r_nd_exc + 1'b1;
                    end
                    if (fire && !node_exc) begin
                        r_nd_inh <= r_nd_inh + 1'b1;
                    end
                    if (32'(node_idx) == 32'(r_probe)) begin
                        r_probe_val <= in_sat;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (32'(r_cnt) == NODE_COUNT - 1) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || o_res.ready) begin
                        r_out_lexc  <= 17'(r_lnk_exc);
                        r_out_linh  <= 17'(r_lnk_inh);
                        r_out_nexc  <= 9'(r_nd_exc);
                        r_out_ninh  <= 9'(r_nd_inh);
                        r_out_probe <= r_probe_val;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_tick_starts_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_xfer && i_cmd.cmd == CMD_TICK |=> r_state == S_ROW && r_exc_in[0] == '0)
        else $error("tick transfer did not start a cleared row pass");

    a_node_no_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_NODE |-> !r_rd_vld && !ram_we)
        else $error("row pipeline busy during node pass");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !i_cmd.ready && !r_out_vld)
        else $error("command taken during clearing pass");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && !r_out_vld |=> r_out_vld && r_state == S_IDLE)
        else $error("finished tick not loaded into output register");

endmodule

// ===== src/ent_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ent_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== tb/tb_ent_if.sv =====
// Network predictor package for the excitable_network_tick testbench.
`timescale 1ns / 100ps
package tb_ent_pred_pkg;
    import ent_pkg::*;

    typedef struct packed {
        logic [16:0]        exc_links;
        logic [16:0]        inh_links;
        logic [8:0]         exc_nodes;
        logic [8:0]         inh_nodes;
        logic signed [12:0] probe;
    } t_tick_sum;

    // mirrored configuration
    int unsigned net_exc_count = 205;
    int unsigned net_exc_time  = 5;
    int unsigned net_inh_time  = 7;
    int          net_threshold = 4;
    int unsigned net_weight    = 4;
    int unsigned net_probe     = 0;

    bit                  net_adj   [NODE_COUNT*NODE_COUNT];
    bit [TIMER_BITS-1:0] net_timer [NODE_COUNT*NODE_COUNT];
    bit                  net_active[NODE_COUNT];
    bit                  net_stim  [NODE_COUNT];

    function automatic void net_write_reg(logic [2:0] idx, logic [12:0] val);
        case (idx)
            REG_EXC_COUNT: net_exc_count = val[8:0];
            REG_EXC_TIME:  net_exc_time  = val[3:0];
            REG_INH_TIME:  net_inh_time  = val[3:0];
            REG_THRESHOLD: net_threshold = $signed(val);
            REG_WEIGHT:    net_weight    = val[3:0];
            REG_PROBE:     net_probe     = val[7:0];
            default: ;
        endcase
    endfunction

    // returns 1 when the command produces a tick summary
    function automatic bit net_apply(logic [1:0] c, logic [7:0] s, logic [7:0] d,
                                     logic e, output t_tick_sum sum);
        int exc_in[NODE_COUNT];
        int inh_in[NODE_COUNT];
        int el, il, en, inn, pv, lim, k, nt, inval;
        bit is_exc;
        sum = '0;
        case (c)
            CMD_EDGE:  begin net_adj[s*NODE_COUNT+d] = e; return 0; end
            CMD_FORCE: begin net_active[s] = 1; return 0; end
            CMD_STIM:  begin net_stim[s] = 1; return 0; end
            default: ;
        endcase
        el = 0; il = 0; en = 0; inn = 0; pv = 0;
        foreach (exc_in[i]) begin exc_in[i] = 0; inh_in[i] = 0; end
        for (int sn = 0; sn < NODE_COUNT; sn++) begin
            is_exc = sn < net_exc_count;
            lim = is_exc ? net_exc_time : net_inh_time;
            for (int dn = 0; dn < NODE_COUNT; dn++) begin
                k = sn*NODE_COUNT + dn;
                if (!net_adj[k]) nt = 0;
                else if (net_timer[k] == 0) nt = net_active[sn];
                else if (net_timer[k] < lim) nt = (net_timer[k] + 1) % (1 << TIMER_BITS);
                else nt = 0;
                net_timer[k] = TIMER_BITS'(nt);
                if (nt != 0) begin
                    if (is_exc) begin el++; exc_in[dn]++; end
                    else begin il++; inh_in[dn]++; end
                end
            end
        end
        for (int dn = 0; dn < NODE_COUNT; dn++) begin
            inval = exc_in[dn] - int'(net_weight) * inh_in[dn];
            if (dn == net_probe) pv = inval;
            net_active[dn] = (inval >= net_threshold) || net_stim[dn];
            net_stim[dn] = 0;
            if (net_active[dn]) begin
                if (dn < net_exc_count) en++; else inn++;
            end
        end
        if (pv > PROBE_MAX) pv = PROBE_MAX;
        if (pv < PROBE_MIN) pv = PROBE_MIN;
        sum.exc_links = 17'(el);
        sum.inh_links = 17'(il);
        sum.exc_nodes = 9'(en);
        sum.inh_nodes = 9'(inn);
        sum.probe = 13'(pv);
        return 1;
    endfunction
endpackage

// ===== tb/tb_excitable_network_tick.sv =====
// Self-checking testbench for excitable_network_tick: directed table, then random traffic.
`timescale 1ns / 100ps
module tb_excitable_network_tick;
    import ent_pkg::*;
    import tb_ent_pred_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam logic [2:0] REG_NONE = 3'd7;

    typedef struct {
        logic [1:0] c;
        logic [7:0] s;
        logic [7:0] d;
        logic       e;
        bit         known;
        t_tick_sum  sum;
    } t_row_stim;

    logic i_clk = 0;
    logic i_rst_n = 0;
    ent_cmd_if cmd_ch();
    ent_res_if res_ch();
    ent_cfg_if cfg_ch();

    excitable_network_tick dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_ch),
                                .o_res(res_ch), .i_cfg(cfg_ch));

    t_tick_sum expected_ticks[$];
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  send_gap_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_recv = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // result sink with random stall and an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 0;
        else res_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_tick_sum want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_ticks.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_ticks.pop_front();
                if (res_ch.active_exc_links !== want.exc_links)
                    report_mismatch("exc_links", res_ch.active_exc_links, want.exc_links);
                if (res_ch.active_inh_links !== want.inh_links)
                    report_mismatch("inh_links", res_ch.active_inh_links, want.inh_links);
                if (res_ch.active_exc_nodes !== want.exc_nodes)
                    report_mismatch("exc_nodes", res_ch.active_exc_nodes, want.exc_nodes);
                if (res_ch.active_inh_nodes !== want.inh_nodes)
                    report_mismatch("inh_nodes", res_ch.active_inh_nodes, want.inh_nodes);
                if (res_ch.probe_input !== want.probe)
                    report_mismatch("probe_input", res_ch.probe_input, want.probe);
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("excitable_network_tick verification failed");
            $finish;
        end
    end

    // valid stays high after a transfer; the next command or a drain takes it down
    task automatic write_reg(logic [2:0] idx, logic [12:0] val);
        cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        net_write_reg(idx, val);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // sends one command; known rows are compared against the typed value too
    task automatic send_cmd(logic [1:0] c, logic [7:0] s, logic [7:0] d, logic e,
                            bit known = 0, t_tick_sum typed = '0);
        t_tick_sum sum;
        cfg_ch.valid <= 1'b0;
        while ($urandom_range(99) < send_gap_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1; cmd_ch.cmd <= c; cmd_ch.src_node <= s;
        cmd_ch.dst_node <= d; cmd_ch.edge_value <= e;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (net_apply(c, s, d, e, sum)) begin
            if (known && sum != typed) report_mismatch("typed row", 0, 1);
            expected_ticks.push_back(sum);
        end
    endtask

    // random item: edges mostly within a small cluster so activity builds up
    task automatic send_random();
        int r;
        logic [7:0] s, d;
        r = $urandom_range(99);
        s = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15)) + 8'd196;
        d = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15)) + 8'd196;
        if (r < 45) send_cmd(CMD_EDGE, s, d, $urandom_range(3) != 0);
        else if (r < 60) send_cmd(CMD_FORCE, s, d, 1'($urandom));
        else if (r < 72) send_cmd(CMD_STIM, s, d, 1'($urandom));
        else send_cmd(CMD_TICK, s, d, 1'($urandom));
    endtask

    task automatic random_phase(int n, int gap, int stall);
        send_gap_pct = gap; recv_stall_pct = stall;
        repeat (n) send_random();
        wait_drained();
    endtask

    t_row_stim table_rows[$];

    initial begin
        t_tick_sum zero_sum;
        zero_sum = '0;
        cmd_ch.valid = 0; cmd_ch.cmd = CMD_EDGE; cmd_ch.src_node = 0;
        cmd_ch.dst_node = 0; cmd_ch.edge_value = 0;
        cfg_ch.valid = 0; cfg_ch.index = REG_EXC_COUNT; cfg_ch.data = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // empty network gives all-zero tick; then extremes of node indexes
        table_rows.push_back('{CMD_TICK, 8'hff, 8'hff, 1'b1, 1'b1, zero_sum});
        table_rows.push_back('{CMD_EDGE, 8'd0, 8'd255, 1'b1, 1'b0, zero_sum});
        table_rows.push_back('{CMD_EDGE, 8'd255, 8'd0, 1'b1, 1'b0, zero_sum});
        table_rows.push_back('{CMD_EDGE, 8'd255, 8'd255, 1'b1, 1'b0, zero_sum});
        table_rows.push_back('{CMD_EDGE, 8'd204, 8'd205, 1'b1, 1'b0, zero_sum});
        table_rows.push_back('{CMD_EDGE, 8'd205, 8'd204, 1'b1, 1'b0, zero_sum});
        table_rows.push_back('{CMD_FORCE, 8'd0, 8'd0, 1'b0, 1'b0, zero_sum});
        table_rows.push_back('{CMD_FORCE, 8'd255, 8'd0, 1'b0, 1'b0, zero_sum});
        table_rows.push_back('{CMD_STIM, 8'd204, 8'd0, 1'b0, 1'b0, zero_sum});
        table_rows.push_back('{CMD_STIM, 8'd205, 8'd0, 1'b0, 1'b0, zero_sum});
        table_rows.push_back('{CMD_TICK, 8'd0, 8'd0, 1'b0, 1'b0, zero_sum});
        table_rows.push_back('{CMD_TICK, 8'd0, 8'd0, 1'b0, 1'b0, zero_sum});
        table_rows.push_back('{CMD_EDGE, 8'd255, 8'd255, 1'b0, 1'b0, zero_sum});
        table_rows.push_back('{CMD_TICK, 8'd0, 8'd0, 1'b0, 1'b0, zero_sum});
        table_rows.push_back('{CMD_TICK, 8'd0, 8'd0, 1'b0, 1'b0, zero_sum});
        foreach (table_rows[i])
            send_cmd(table_rows[i].c, table_rows[i].s, table_rows[i].d, table_rows[i].e,
                     table_rows[i].known, table_rows[i].sum);
        wait_drained();

        // extremes: all excitatory, active time 1, lowest threshold, no weight, probe top
        write_reg(REG_EXC_COUNT, 13'd256);
        write_reg(REG_EXC_TIME, 13'd1);
        write_reg(REG_INH_TIME, 13'd15);
        write_reg(REG_THRESHOLD, 13'h1000);
        write_reg(REG_WEIGHT, 13'd0);
        write_reg(REG_PROBE, 13'd255);
        write_reg(REG_NONE, 13'h1fff);
        send_cmd(CMD_TICK, 8'd0, 8'd0, 1'b0);
        send_cmd(CMD_TICK, 8'd0, 8'd0, 1'b0);
        wait_drained();
        write_reg(REG_EXC_COUNT, 13'd0);
        write_reg(REG_THRESHOLD, 13'h0fff);
        write_reg(REG_WEIGHT, 13'd15);
        write_reg(REG_EXC_TIME, 13'd15);
        write_reg(REG_INH_TIME, 13'd0);
        write_reg(REG_PROBE, 13'd205);
        send_cmd(CMD_TICK, 8'd0, 8'd0, 1'b0);
        wait_drained();
        // active time zero on both kinds gives one-tick links
        write_reg(REG_EXC_COUNT, 13'd200);
        write_reg(REG_EXC_TIME, 13'd0);
        write_reg(REG_THRESHOLD, 13'd1);
        send_cmd(CMD_FORCE, 8'd0, 8'd0, 1'b0);
        send_cmd(CMD_TICK, 8'd0, 8'd0, 1'b0);
        wait_drained();

        // reset-like setting, well-formed traffic; sender idle 9%, receiver 66%
        write_reg(REG_EXC_COUNT, 13'd205);
        write_reg(REG_EXC_TIME, 13'd5);
        write_reg(REG_INH_TIME, 13'd7);
        write_reg(REG_THRESHOLD, 13'd1);
        write_reg(REG_WEIGHT, 13'd2);
        write_reg(REG_PROBE, 13'd200);
        random_phase(300, 9, 66);

        // long receiver hold-off while ticks queue up
        hold_recv <= 1'b1;
        fork
            begin repeat (4000) @(posedge i_clk); hold_recv <= 1'b0; end
            begin
                send_gap_pct = 0;
                repeat (6) send_cmd(CMD_TICK, 8'd0, 8'd0, 1'b0);
                wait_drained();
            end
        join

        write_reg(REG_EXC_COUNT, 13'd210);
        write_reg(REG_EXC_TIME, 13'd3);
        write_reg(REG_INH_TIME, 13'd2);
        write_reg(REG_THRESHOLD, 13'h1ffe);
        write_reg(REG_WEIGHT, 13'd1);
        write_reg(REG_PROBE, 13'd198);
        random_phase(300, 66, 9);

        write_reg(REG_EXC_COUNT, 13'd203);
        write_reg(REG_EXC_TIME, 13'd15);
        write_reg(REG_THRESHOLD, 13'd2);
        random_phase(300, 0, 0);

        repeat (600) @(posedge i_clk);
        if (mismatch_count == 0 && expected_ticks.size() == 0)
            $display("excitable_network_tick verification clean");
        else
            $display("excitable_network_tick verification failed");
        $finish;
    end
endmodule
